// File: rtl/core/button_click_event_detector_top_macros.svh
// Assertion macros for the button click event detector.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_TOP_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bced_pkg.sv
// Shared codes and types for the button click event detector.
`default_nettype none
package bced_pkg;
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_DOWN       = 3'd1;
    localparam logic [2:0] EV_UP         = 3'd2;
    localparam logic [2:0] EV_REPEAT     = 3'd3;
    localparam logic [2:0] EV_SINGLE     = 3'd4;
    localparam logic [2:0] EV_DOUBLE     = 3'd5;
    localparam logic [2:0] EV_LONG_START = 3'd6;
    localparam logic [2:0] EV_LONG_HOLD  = 3'd7;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PRESSED   = 3'd1;
    localparam logic [2:0] PH_WAIT      = 3'd2;
    localparam logic [2:0] PH_REPRESSED = 3'd3;
    localparam logic [2:0] PH_LONG      = 3'd5;

    localparam logic [2:0] REG_ACTIVE_LEVEL   = 3'd0;
    localparam logic [2:0] REG_INITIAL_LEVEL  = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd2;
    localparam logic [2:0] REG_SHORT_TICKS    = 3'd3;
    localparam logic [2:0] REG_LONG_TICKS     = 3'd4;

    localparam int CFG_W = 16;

    // Results of one tick: up to three events, index of the last, recorded event.
    typedef struct packed {
        logic [2:0] ev0;
        logic [2:0] ev1;
        logic [2:0] ev2;
        logic [1:0] last_idx;
        logic [2:0] status;
    } t_bundle;
endpackage
`default_nettype wire

// File: rtl/core/button_click_event_detector_top.sv
// Top level of the button click event detector: debounce, click machine, result queue.
//
// Input channel: i_valid / o_stall carry one raw button level per tick; a tick
// is transferred at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry result items, one to three per tick,
// with o_last_of_tick marking the final one; a tick that fires nothing gives a
// single item with event code none.
// Latency: a tick's first result shows the cycle after its transfer if the shown entry
// is free or being released. Throughput: one tick per cycle while each tick gives one
// result and the receiver does not stall; a tick with more results holds the output
// until each is taken; the two-entry result queue (one presenting, one waiting) sets
// how far input runs ahead. Stall: while the receiver stalls, the shown result holds;
// one more tick fills the waiting entry, then o_stall stays high until that moves up.
// Configuration: i_cfg_we writes register i_cfg_idx from i_cfg_data; writing
// initial_level also reloads the stable level and clears the debounce count. Writes
// must be made only while the block is idle; the block itself does not enforce this.
// Reset (synchronous, active low): registers return to defaults, the machine
// goes idle, the stable level resets high and both queue entries empty.
`default_nettype none
module button_click_event_detector_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_raw_level,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_res,
    output logic             o_last_of_tick,
    output logic [2:0]       o_status_event,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import bced_pkg::*;

    // configuration
    logic        r_active_level;
    logic [7:0]  r_debounce_ticks;
    logic [15:0] r_short_ticks;
    logic [15:0] r_long_ticks;

    // machine state
    logic [2:0]  r_phase,  n_phase;
    logic        r_stable, n_stable;
    logic [7:0]  r_dcnt,   n_dcnt;
    logic [15:0] r_tick,   n_tick;
    logic [7:0]  r_press,  n_press;
    logic [2:0]  r_rec,    n_rec;
    t_bundle     n_bundle;

    // result queue
    t_bundle     r_b0, r_b1;
    logic        r_b0_valid, r_b1_valid;
    logic [1:0]  r_idx;

    logic        in_xfer, out_xfer, pop0;
    logic        pressed;

    assign o_stall  = r_b1_valid;
    assign in_xfer  = i_valid && !r_b1_valid;
    assign o_valid  = r_b0_valid;
    assign out_xfer = r_b0_valid && !i_stall;
    assign pop0     = out_xfer && (r_idx == r_b0.last_idx);

    always_comb begin
        n_phase  = r_phase;
        n_stable = r_stable;
        n_dcnt   = r_dcnt;
        n_tick   = r_tick;
        n_press  = r_press;
        n_rec    = r_rec;
        n_bundle = '0;
        n_bundle.ev0 = EV_NONE;

        if (r_phase != PH_IDLE && r_tick != 16'hFFFF) begin
            n_tick = r_tick + 16'd1;
        end

        if (i_raw_level != r_stable) begin
            if (r_dcnt != 8'hFF) begin
                n_dcnt = r_dcnt + 8'd1;
            end
            if (n_dcnt >= r_debounce_ticks) begin
                n_stable = i_raw_level;
                n_dcnt   = '0;
            end
        end else begin
            n_dcnt = '0;
        end

        pressed = (n_stable == r_active_level);

        case (r_phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_rec        = EV_DOWN;
                    n_bundle.ev0 = EV_DOWN;
                    n_tick       = '0;
                    n_press      = 8'd1;
                    n_phase      = PH_PRESSED;
                end else begin
                    n_rec = EV_NONE;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    n_rec        = EV_UP;
                    n_bundle.ev0 = EV_UP;
                    n_tick       = '0;
                    n_phase      = PH_WAIT;
                end else if (n_tick > r_long_ticks) begin
                    n_rec        = EV_LONG_START;
                    n_bundle.ev0 = EV_LONG_START;
                    n_phase      = PH_LONG;
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    n_rec        = EV_DOWN;
                    n_bundle.ev0 = EV_DOWN;
                    if (r_press != 8'hFF) begin
                        n_press = r_press + 8'd1;
                    end
                    if (n_press == 8'd2) begin
                        n_bundle.ev1      = EV_DOUBLE;
                        n_bundle.ev2      = EV_REPEAT;
                        n_bundle.last_idx = 2'd2;
                    end else begin
                        n_bundle.ev1      = EV_REPEAT;
                        n_bundle.last_idx = 2'd1;
                    end
                    n_tick  = '0;
                    n_phase = PH_REPRESSED;
                end else if (n_tick > r_short_ticks) begin
                    // three or more clicks fire nothing and keep the record
                    if (r_press == 8'd1) begin
                        n_rec        = EV_SINGLE;
                        n_bundle.ev0 = EV_SINGLE;
                    end else if (r_press == 8'd2) begin
                        n_rec        = EV_DOUBLE;
                        n_bundle.ev0 = EV_DOUBLE;
                    end
                    n_phase = PH_IDLE;
                end
            end
            PH_REPRESSED: begin
                if (!pressed) begin
                    n_rec        = EV_UP;
                    n_bundle.ev0 = EV_UP;
                    if (n_tick < r_short_ticks) begin
                        n_tick  = '0;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_LONG: begin
                if (pressed) begin
                    n_rec        = EV_LONG_HOLD;
                    n_bundle.ev0 = EV_LONG_HOLD;
                end else begin
                    n_rec        = EV_UP;
                    n_bundle.ev0 = EV_UP;
                    n_phase      = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        n_bundle.status = n_rec;
    end

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level   <= 1'b0;
            r_debounce_ticks <= 8'd3;
            r_short_ticks    <= 16'd20;
            r_long_ticks     <= 16'd100;
            r_phase          <= PH_IDLE;
            r_stable         <= 1'b1;
            r_dcnt           <= '0;
            r_tick           <= '0;
            r_press          <= '0;
            r_rec            <= EV_NONE;
        end else begin
            if (in_xfer) begin
                r_phase  <= n_phase;
                r_stable <= n_stable;
                r_dcnt   <= n_dcnt;
                r_tick   <= n_tick;
                r_press  <= n_press;
                r_rec    <= n_rec;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACTIVE_LEVEL:   r_active_level   <= i_cfg_data[0];
                    REG_INITIAL_LEVEL: begin
                        // reload as a fresh sample at init
                        r_stable <= i_cfg_data[0];
                        r_dcnt   <= '0;
                    end
                    REG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[7:0];
                    REG_SHORT_TICKS:    r_short_ticks    <= i_cfg_data[CFG_W-1:0];
                    REG_LONG_TICKS:     r_long_ticks     <= i_cfg_data[CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid <= 1'b0;
            r_b1_valid <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (pop0 || !r_b0_valid) begin
                r_idx <= '0;
                if (r_b1_valid) begin
                    r_b0_valid <= 1'b1;
                    r_b1_valid <= 1'b0;
                end else begin
                    r_b0_valid <= in_xfer;
                end
            end else begin
                if (out_xfer) begin
                    r_idx <= r_idx + 2'd1;
                end
                if (in_xfer) begin
                    r_b1_valid <= 1'b1;
                end
            end
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (pop0 || !r_b0_valid) begin
            r_b0 <= r_b1_valid ? r_b1 : n_bundle;
        end else if (in_xfer) begin
            r_b1 <= n_bundle;
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    o_event_res = r_b0.ev0;
            2'd1:    o_event_res = r_b0.ev1;
            2'd2:    o_event_res = r_b0.ev2;
            default: o_event_res = EV_NONE;
        endcase
    end

    assign o_last_of_tick = (r_idx == r_b0.last_idx);
    assign o_status_event = r_b0.status;

`include "button_click_event_detector_top_macros.svh"

    `BCED_ASSERT_NOW(a_queue_order, r_b1_valid, r_b0_valid, "waiting entry without a shown one")
    `BCED_ASSERT_NOW(a_idx_range, r_b0_valid, (r_idx <= r_b0.last_idx) && (r_b0.last_idx != 2'd3), "result index beyond tick")
    `BCED_ASSERT_NEXT(a_tick_continues, o_valid && !i_stall && !o_last_of_tick, o_valid && (r_idx == $past(r_idx) + 2'd1), "tick results cut short")

endmodule
`default_nettype wire
